[src/gpcsc_pkg.sv]
// Shared types and codes for the 2D partition CSC builder.
// No dependencies.
`default_nettype none
package gpcsc_pkg;

    localparam logic [1:0] OP_LOAD     = 2'd0;
    localparam logic [1:0] OP_BUILD    = 2'd1;
    localparam logic [1:0] OP_RD_OFF   = 2'd2;
    localparam logic [1:0] OP_RD_ROW   = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_OWNED = 3'd1;
    localparam logic [2:0] ST_BAD_NODE  = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_RANGE     = 3'd4;

    localparam logic [2:0] CFG_NODE_COUNT = 3'd0;
    localparam logic [2:0] CFG_GRID_ROWS  = 3'd1;
    localparam logic [2:0] CFG_GRID_COLS  = 3'd2;
    localparam logic [2:0] CFG_MY_ROW     = 3'd3;
    localparam logic [2:0] CFG_MY_COL     = 3'd4;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] source_node;
        logic [15:0] target_node;
        logic [12:0] position;
    } t_in_item;

    typedef struct packed {
        logic [15:0] value;
        logic [2:0]  status;
    } t_out_item;

    typedef struct packed {
        logic [15:0] node_count;
        logic [4:0]  grid_rows;
        logic [4:0]  grid_cols;
        logic [3:0]  my_row;
        logic [3:0]  my_col;
    } t_cfg;

    // classified command; for a build, col carries the column count
    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  status;
        logic [15:0] col;
        logic [15:0] row;
        logic [7:0]  blk;
        logic [12:0] pos;
    } t_cmd;

endpackage
`default_nettype wire

[src/gpcsc_div.sv]
// Iterative 16-bit restoring divider, one quotient bit per cycle.
// No dependencies.
`default_nettype none
module gpcsc_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [15:0] i_dividend,
    input  wire logic [15:0] i_divisor,
    output logic             o_done,
    output logic [15:0]      o_quot,
    output logic [15:0]      o_rem
);
    logic        r_busy, n_busy, r_done, n_done;
    logic [3:0]  r_cnt, n_cnt;
    logic [15:0] r_rem, n_rem, r_quo, n_quo, r_dvs, n_dvs;
    logic [16:0] w_trial;

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_dvs   = r_dvs;
        w_trial = {r_rem, r_quo[15]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 4'd15;
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_dvs}) begin
                n_rem = 16'(w_trial - {1'b0, r_dvs});
                n_quo = {r_quo[14:0], 1'b1};
            end else begin
                n_rem = w_trial[15:0];
                n_quo = {r_quo[14:0], 1'b0};
            end
            n_cnt = r_cnt - 4'd1;
            if (r_cnt == 4'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;
endmodule
`default_nettype wire

[src/gpcsc_front.sv]
// Front end: takes requests, checks ownership of edges and queues commands.
// Depends on gpcsc_pkg and gpcsc_div.
`default_nettype none
module gpcsc_front #(
    parameter int MAX_LOCAL_COLS = 1024
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire gpcsc_pkg::t_cfg   i_cfg,
    input  wire logic              i_cfg_wr,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire gpcsc_pkg::t_in_item i_item,
    input  wire logic              i_full,
    output logic                   o_push,
    output gpcsc_pkg::t_cmd        o_cmd
);
    typedef enum logic [7:0] {
        S_IDLE = 8'h01,
        S_EVAL = 8'h02,
        S_DC   = 8'h04,
        S_DR   = 8'h08,
        S_CHK  = 8'h10,
        S_DB   = 8'h20,
        S_DM   = 8'h40,
        S_PUSH = 8'h80
    } t_fstate;

    t_fstate             r_state, n_state;
    gpcsc_pkg::t_in_item r_in, n_in;
    gpcsc_pkg::t_cmd     r_cmd, n_cmd;
    logic                r_dirty, n_dirty;
    logic [15:0]         r_bsc, n_bsc, r_bsr, n_bsr;

    logic        w_start, w_done;
    logic [15:0] w_dvd, w_dvs, w_quot, w_rem;
    logic [15:0] w_col, w_row;
    logic [9:0]  w_rc;
    logic [19:0] w_lo, w_diff;
    logic        w_bad;

    gpcsc_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
        .i_dividend(w_dvd), .i_divisor(w_dvs),
        .o_done(w_done), .o_quot(w_quot), .o_rem(w_rem)
    );

    assign w_col  = r_in.source_node - 16'd1;
    assign w_row  = r_in.target_node - 16'd1;
    assign w_rc   = 10'(i_cfg.grid_rows) * 10'(i_cfg.grid_cols);
    assign w_lo   = 20'(i_cfg.my_col) * 20'(r_bsc);
    assign w_diff = 20'(w_col) - w_lo;
    assign w_bad  = (r_in.source_node == 16'd0) || (r_in.target_node == 16'd0) ||
                    (r_in.source_node > i_cfg.node_count) ||
                    (r_in.target_node > i_cfg.node_count);

    always_comb begin
        n_state = r_state;
        n_in    = r_in;
        n_cmd   = r_cmd;
        n_dirty = r_dirty;
        n_bsc   = r_bsc;
        n_bsr   = r_bsr;
        w_start = 1'b0;
        w_dvd   = i_cfg.node_count;
        w_dvs   = 16'(i_cfg.grid_cols);
        o_push  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_in      = i_item;
                    n_cmd     = '0;
                    n_cmd.op  = i_item.op;
                    n_cmd.pos = i_item.position;
                    n_state   = S_EVAL;
                end
            end
            S_EVAL: begin
                if (r_in.op == gpcsc_pkg::OP_LOAD) begin
                    if (w_bad) begin
                        n_cmd.status = gpcsc_pkg::ST_BAD_NODE;
                        n_state      = S_PUSH;
                    end else if (i_cfg.grid_rows == 5'd0 || i_cfg.grid_cols == 5'd0) begin
                        n_cmd.status = gpcsc_pkg::ST_NOT_OWNED;
                        n_state      = S_PUSH;
                    end else if (r_dirty) begin
                        w_start = 1'b1;
                        n_state = S_DC;
                    end else begin
                        n_state = S_CHK;
                    end
                end else if (r_in.op == gpcsc_pkg::OP_BUILD) begin
                    if (i_cfg.grid_cols == 5'd0) begin
                        n_cmd.col = '0;
                        n_state   = S_PUSH;
                    end else if (r_dirty) begin
                        w_start = 1'b1;
                        n_state = S_DC;
                    end else begin
                        n_cmd.col = (32'(r_bsc) > 32'(MAX_LOCAL_COLS)) ?
                                    16'(MAX_LOCAL_COLS) : r_bsc;
                        n_state   = S_PUSH;
                    end
                end else begin
                    n_state = S_PUSH;
                end
            end
            S_DC: begin
                if (w_done) begin
                    n_bsc = w_quot;
                    if (w_rc == 10'd0) begin
                        n_bsr   = '0;
                        n_dirty = 1'b0;
                        n_state = S_EVAL;
                    end else begin
                        w_start = 1'b1;
                        w_dvs   = 16'(w_rc);
                        n_state = S_DR;
                    end
                end
            end
            S_DR: begin
                if (w_done) begin
                    n_bsr   = w_quot;
                    n_dirty = 1'b0;
                    n_state = S_EVAL;
                end
            end
            S_CHK: begin
                if (r_bsc == 16'd0 || r_bsr == 16'd0 ||
                    5'(i_cfg.my_col) >= i_cfg.grid_cols ||
                    20'(w_col) < w_lo || w_diff >= 20'(r_bsc)) begin
                    n_cmd.status = gpcsc_pkg::ST_NOT_OWNED;
                    n_state      = S_PUSH;
                end else begin
                    w_start = 1'b1;
                    w_dvd   = w_row;
                    w_dvs   = r_bsr;
                    n_state = S_DB;
                end
            end
            S_DB: begin
                if (w_done) begin
                    if (w_quot >= 16'(w_rc)) begin
                        n_cmd.status = gpcsc_pkg::ST_NOT_OWNED;
                        n_state      = S_PUSH;
                    end else begin
                        w_start = 1'b1;
                        w_dvd   = w_quot;
                        w_dvs   = 16'(i_cfg.grid_rows);
                        n_state = S_DM;
                    end
                end
            end
            S_DM: begin
                if (w_done) begin
                    n_cmd.col = 16'(w_diff);
                    n_cmd.row = w_row;
                    n_cmd.blk = w_quot[7:0];
                    if (w_rem != 16'(i_cfg.my_row)) begin
                        n_cmd.status = gpcsc_pkg::ST_NOT_OWNED;
                    end else if (32'(w_diff) >= 32'(MAX_LOCAL_COLS)) begin
                        n_cmd.status = gpcsc_pkg::ST_FULL;
                    end else begin
                        n_cmd.status = gpcsc_pkg::ST_OK;
                    end
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (i_cfg_wr) begin
            n_dirty = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dirty <= 1'b1;
        end else begin
            r_state <= n_state;
            r_dirty <= n_dirty;
        end
        r_in  <= n_in;
        r_cmd <= n_cmd;
        r_bsc <= n_bsc;
        r_bsr <= n_bsr;
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_cmd   = r_cmd;
endmodule
`default_nettype wire

[src/gpcsc_fifo.sv]
// Short command queue between front and back end.
// Depends on gpcsc_pkg.
`default_nettype none
module gpcsc_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire gpcsc_pkg::t_cmd i_data,
    output logic                 o_full,
    input  wire logic            i_pop,
    output gpcsc_pkg::t_cmd      o_data,
    output logic                 o_empty
);
    localparam int PW = $clog2(DEPTH);

    gpcsc_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [PW:0]     r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (PW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - (PW+1)'(1);
            end
        end
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
endmodule
`default_nettype wire

[src/gpcsc_back.sv]
// Back end: edge store, build sequencer, offset/cursor/row tables, result register.
// Depends on gpcsc_pkg.
`default_nettype none
module gpcsc_back #(
    parameter int MAX_EDGES      = 4096,
    parameter int MAX_LOCAL_COLS = 1024
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_empty,
    input  wire gpcsc_pkg::t_cmd i_cmd,
    output logic                 o_pop,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output gpcsc_pkg::t_out_item o_item
);
    localparam int EW = $clog2(MAX_EDGES + 1);
    localparam int AW = $clog2(MAX_EDGES);
    localparam int CW = $clog2(MAX_LOCAL_COLS + 1);
    localparam int LW = $clog2(MAX_LOCAL_COLS);
    localparam int DW = LW + 24;

    typedef enum logic [12:0] {
        B_IDLE    = 13'h0001,
        B_RDOFF   = 13'h0002,
        B_RDROW   = 13'h0004,
        B_CLR     = 13'h0008,
        B_CNT_RD  = 13'h0010,
        B_CNT_OFF = 13'h0020,
        B_CNT_WR  = 13'h0040,
        B_PRE_RD  = 13'h0080,
        B_PRE_WR  = 13'h0100,
        B_SC_RD   = 13'h0200,
        B_SC_CUR  = 13'h0400,
        B_SC_WR   = 13'h0800,
        B_DONE    = 13'h1000
    } t_bstate;

    logic [DW-1:0] r_emem [MAX_EDGES];
    logic [EW-1:0] r_omem [MAX_LOCAL_COLS + 1];
    logic [EW-1:0] r_cmem [MAX_LOCAL_COLS + 1];
    logic [15:0]   r_rmem [MAX_EDGES];
    logic [DW-1:0] r_e_rd;
    logic [EW-1:0] r_o_rd, r_c_rd;
    logic [15:0]   r_r_rd;

    logic          e_we, o_we, c_we, w_we;
    logic [AW-1:0] e_wa, w_wa, w_ra;
    logic [CW-1:0] o_wa, o_ra, c_wa, c_ra;
    logic [DW-1:0] e_wd;
    logic [EW-1:0] o_wd, c_wd;
    logic [15:0]   w_wd;

    t_bstate              r_state, n_state;
    logic [EW-1:0]        r_cnt, n_cnt, r_btotal, n_btotal, r_acc, n_acc;
    logic                 r_built, n_built, r_ov, n_ov;
    logic [15:0]          r_bcols, n_bcols, r_erow, n_erow;
    logic [CW-1:0]        r_ncols, n_ncols, r_c, n_c, r_ecol, n_ecol;
    logic [AW-1:0]        r_idx, n_idx;
    logic [7:0]           r_mmax, n_mmax, r_m, n_m;
    gpcsc_pkg::t_out_item r_out, n_out;

    logic [CW-1:0] w_col;
    logic [15:0]   w_row;
    logic [7:0]    w_blk;
    logic          w_free, w_last;
    logic [EW-1:0] w_sum;

    assign w_col  = CW'(r_e_rd[DW-1:24]);
    assign w_row  = r_e_rd[23:8];
    assign w_blk  = r_e_rd[7:0];
    assign w_free = !r_ov || i_ready;
    assign w_last = (EW'(r_idx) + EW'(1) == r_cnt);
    assign w_sum  = r_acc + r_o_rd;

    always_ff @(posedge i_clk) begin
        if (e_we) r_emem[e_wa] <= e_wd;
        r_e_rd <= r_emem[r_idx];
        if (o_we) r_omem[o_wa] <= o_wd;
        r_o_rd <= r_omem[o_ra];
        if (c_we) r_cmem[c_wa] <= c_wd;
        r_c_rd <= r_cmem[c_ra];
        if (w_we) r_rmem[w_wa] <= w_wd;
        r_r_rd <= r_rmem[w_ra];
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_btotal = r_btotal;
        n_acc    = r_acc;
        n_built  = r_built;
        n_bcols  = r_bcols;
        n_erow   = r_erow;
        n_ncols  = r_ncols;
        n_c      = r_c;
        n_ecol   = r_ecol;
        n_idx    = r_idx;
        n_mmax   = r_mmax;
        n_m      = r_m;
        n_out    = r_out;
        n_ov     = r_ov && !i_ready;
        o_pop    = 1'b0;
        e_we = 1'b0; e_wa = AW'(r_cnt);
        e_wd = {LW'(i_cmd.col), i_cmd.row, i_cmd.blk};
        o_we = 1'b0; o_wa = r_c; o_wd = '0; o_ra = r_c;
        c_we = 1'b0; c_wa = r_c; c_wd = w_sum; c_ra = w_col;
        w_we = 1'b0; w_wa = AW'(r_c_rd); w_wd = r_erow; w_ra = AW'(i_cmd.pos);
        unique case (r_state)
            B_IDLE: begin
                if (!i_empty && w_free) begin
                    o_pop = 1'b1;
                    unique case (i_cmd.op)
                        gpcsc_pkg::OP_LOAD: begin
                            n_built = 1'b0;
                            n_ov    = 1'b1;
                            n_out   = '{value: '0, status: i_cmd.status};
                            if (i_cmd.status == gpcsc_pkg::ST_OK) begin
                                if (32'(r_cnt) >= 32'(MAX_EDGES)) begin
                                    n_out.status = gpcsc_pkg::ST_FULL;
                                end else begin
                                    e_we  = 1'b1;
                                    n_cnt = r_cnt + EW'(1);
                                end
                            end
                        end
                        gpcsc_pkg::OP_BUILD: begin
                            n_ncols = CW'(i_cmd.col);
                            n_bcols = i_cmd.col;
                            n_c     = '0;
                            n_mmax  = '0;
                            n_state = B_CLR;
                        end
                        gpcsc_pkg::OP_RD_OFF: begin
                            o_ra = CW'(i_cmd.pos);
                            if (r_built && 16'(i_cmd.pos) <= r_bcols) begin
                                n_state = B_RDOFF;
                            end else begin
                                n_ov  = 1'b1;
                                n_out = '{value: '0, status: gpcsc_pkg::ST_RANGE};
                            end
                        end
                        default: begin
                            if (r_built && 32'(i_cmd.pos) < 32'(r_btotal) &&
                                32'(i_cmd.pos) < 32'(MAX_EDGES)) begin
                                n_state = B_RDROW;
                            end else begin
                                n_ov  = 1'b1;
                                n_out = '{value: '0, status: gpcsc_pkg::ST_RANGE};
                            end
                        end
                    endcase
                end
            end
            B_RDOFF: begin
                n_ov    = 1'b1;
                n_out   = '{value: 16'(r_o_rd), status: gpcsc_pkg::ST_OK};
                n_state = B_IDLE;
            end
            B_RDROW: begin
                n_ov    = 1'b1;
                n_out   = '{value: r_r_rd, status: gpcsc_pkg::ST_OK};
                n_state = B_IDLE;
            end
            B_CLR: begin
                o_we = 1'b1;
                if (r_c == r_ncols) begin
                    n_idx   = '0;
                    n_c     = '0;
                    n_acc   = '0;
                    n_state = (r_cnt == '0) ? B_PRE_RD : B_CNT_RD;
                end else begin
                    n_c = r_c + CW'(1);
                end
            end
            B_CNT_RD: n_state = B_CNT_OFF;
            B_CNT_OFF: begin
                o_ra = w_col + CW'(1);
                if (w_col < r_ncols) begin
                    n_ecol  = w_col;
                    if (w_blk > r_mmax) n_mmax = w_blk;
                    n_state = B_CNT_WR;
                end else if (w_last) begin
                    n_state = B_PRE_RD;
                end else begin
                    n_idx   = r_idx + AW'(1);
                    n_state = B_CNT_RD;
                end
            end
            B_CNT_WR: begin
                o_we = 1'b1;
                o_wa = r_ecol + CW'(1);
                o_wd = r_o_rd + EW'(1);
                if (w_last) begin
                    n_state = B_PRE_RD;
                end else begin
                    n_idx   = r_idx + AW'(1);
                    n_state = B_CNT_RD;
                end
            end
            B_PRE_RD: n_state = B_PRE_WR;
            B_PRE_WR: begin
                o_we  = 1'b1;
                o_wd  = w_sum;
                c_we  = 1'b1;
                n_acc = w_sum;
                if (r_c == r_ncols) begin
                    n_idx   = '0;
                    n_m     = '0;
                    n_state = (r_cnt == '0) ? B_DONE : B_SC_RD;
                end else begin
                    n_c     = r_c + CW'(1);
                    n_state = B_PRE_RD;
                end
            end
            B_SC_RD: n_state = B_SC_CUR;
            B_SC_CUR: begin
                if (w_col < r_ncols && w_blk == r_m) begin
                    n_ecol  = w_col;
                    n_erow  = w_row;
                    n_state = B_SC_WR;
                end else if (w_last) begin
                    if (r_m == r_mmax) begin
                        n_state = B_DONE;
                    end else begin
                        n_m     = r_m + 8'd1;
                        n_idx   = '0;
                        n_state = B_SC_RD;
                    end
                end else begin
                    n_idx   = r_idx + AW'(1);
                    n_state = B_SC_RD;
                end
            end
            B_SC_WR: begin
                w_we = (32'(r_c_rd) < 32'(MAX_EDGES));
                c_we = 1'b1;
                c_wa = r_ecol;
                c_wd = r_c_rd + EW'(1);
                if (w_last) begin
                    if (r_m == r_mmax) begin
                        n_state = B_DONE;
                    end else begin
                        n_m     = r_m + 8'd1;
                        n_idx   = '0;
                        n_state = B_SC_RD;
                    end
                end else begin
                    n_idx   = r_idx + AW'(1);
                    n_state = B_SC_RD;
                end
            end
            B_DONE: begin
                n_built  = 1'b1;
                n_btotal = r_acc;
                n_ov     = 1'b1;
                n_out    = '{value: 16'(r_acc), status: gpcsc_pkg::ST_OK};
                n_state  = B_IDLE;
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_cnt    <= '0;
            r_built  <= 1'b0;
            r_ov     <= 1'b0;
            r_btotal <= '0;
            r_bcols  <= '0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_built  <= n_built;
            r_ov     <= n_ov;
            r_btotal <= n_btotal;
            r_bcols  <= n_bcols;
        end
        r_acc   <= n_acc;
        r_erow  <= n_erow;
        r_ncols <= n_ncols;
        r_c     <= n_c;
        r_ecol  <= n_ecol;
        r_idx   <= n_idx;
        r_mmax  <= n_mmax;
        r_m     <= n_m;
        r_out   <= n_out;
    end

    assign o_valid = r_ov;
    assign o_item  = r_out;
endmodule
`default_nettype wire

[src/graph_2d_partition_csc_builder_unit.sv]
// Top level of the 2D partition CSC builder: config registers, front, queue, back.
// Depends on gpcsc_pkg, gpcsc_front, gpcsc_fifo, gpcsc_back.
//
// Every request gives exactly one result, in order, and the front takes a new request
// only once the previous one is queued. Reads, and loads turned away for a bad node or
// an empty grid, need no divider pass, nor does a load outside the column slice. A load
// that fails the row-block check runs one pass of the serial divider (row block), and an
// owned load runs two (row block, then block modulo rows). The first load or build after
// a config write that is not turned away at once adds two more divider passes. A build
// walks the tables one entry at a time: it clears the cols+1 offset entries, counts the
// edges per column, forms the prefix sum over the entries, then places the edges of each
// row block up to the largest; cols is min(node_count/grid_cols, MAX_LOCAL_COLS).
// Up to four classified requests queue between front and back.
`default_nettype none
module graph_2d_partition_csc_builder_unit #(
    parameter int MAX_EDGES      = 4096,
    parameter int MAX_LOCAL_COLS = 1024
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [2:0]           i_cfg_idx,
    input  wire logic [15:0]          i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire gpcsc_pkg::t_in_item  i_in_item,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output gpcsc_pkg::t_out_item      o_out_item
);
    gpcsc_pkg::t_cfg r_cfg;
    gpcsc_pkg::t_cmd w_fcmd, w_qcmd;
    logic            w_push, w_full, w_pop, w_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{node_count: 16'd1024, grid_rows: 5'd1, grid_cols: 5'd1,
                       my_row: 4'd0, my_col: 4'd0};
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                gpcsc_pkg::CFG_NODE_COUNT: r_cfg.node_count <= i_cfg_data;
                gpcsc_pkg::CFG_GRID_ROWS:  r_cfg.grid_rows  <= i_cfg_data[4:0];
                gpcsc_pkg::CFG_GRID_COLS:  r_cfg.grid_cols  <= i_cfg_data[4:0];
                gpcsc_pkg::CFG_MY_ROW:     r_cfg.my_row     <= i_cfg_data[3:0];
                gpcsc_pkg::CFG_MY_COL:     r_cfg.my_col     <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    gpcsc_front #(.MAX_LOCAL_COLS(MAX_LOCAL_COLS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg), .i_cfg_wr(i_cfg_we),
        .i_valid(i_in_valid), .o_ready(o_in_ready), .i_item(i_in_item),
        .i_full(w_full), .o_push(w_push), .o_cmd(w_fcmd)
    );

    gpcsc_fifo #(.DEPTH(4)) u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_push), .i_data(w_fcmd),
        .o_full(w_full), .i_pop(w_pop), .o_data(w_qcmd), .o_empty(w_empty)
    );

    gpcsc_back #(.MAX_EDGES(MAX_EDGES), .MAX_LOCAL_COLS(MAX_LOCAL_COLS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(w_empty), .i_cmd(w_qcmd),
        .o_pop(w_pop), .o_valid(o_out_valid), .i_ready(i_out_ready),
        .o_item(o_out_item)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("queue push while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("queue pop while empty");

    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("outputs not idle after reset");
endmodule
`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for graph_2d_partition_csc_builder_unit: edge loads, builds
// and table reads are predicted by an in-bench CSC model and checked in order.
// Depends on gpcsc_pkg and the RTL top level only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = 4096;
    localparam int COL_LIMIT   = 1024;
    localparam int CYCLE_LIMIT = 3000000;

    class csc_scoreboard;
        int unsigned nodes = 1024, rows_r = 1, cols_c = 1, mrow = 0, mcol = 0;
        int unsigned edge_col[STORE_DEPTH];
        int unsigned edge_row[STORE_DEPTH];
        int unsigned edge_blk[STORE_DEPTH];
        int unsigned kept = 0;
        int unsigned col_off[COL_LIMIT + 1];
        int unsigned row_idx[STORE_DEPTH];
        bit          built = 0;
        int unsigned built_cols = 0, built_total = 0;
        gpcsc_pkg::t_out_item result_q[$];
        int          mismatches = 0, checked = 0, full_hits = 0, builds = 0;

        function logic [2:0] load_edge(int unsigned src, int unsigned dst);
            int unsigned bsc, bsr, col, row, lo, b;
            built = 0;
            if (src == 0 || dst == 0 || src > nodes || dst > nodes)
                return gpcsc_pkg::ST_BAD_NODE;
            if (rows_r == 0 || cols_c == 0) return gpcsc_pkg::ST_NOT_OWNED;
            bsc = nodes / cols_c;
            bsr = nodes / (rows_r * cols_c);
            if (bsc == 0 || bsr == 0) return gpcsc_pkg::ST_NOT_OWNED;
            col = src - 1;
            row = dst - 1;
            lo = mcol * bsc;
            if (mcol >= cols_c || col < lo || col - lo >= bsc) return gpcsc_pkg::ST_NOT_OWNED;
            b = row / bsr;
            if (b >= rows_r * cols_c || (b % rows_r) != mrow) return gpcsc_pkg::ST_NOT_OWNED;
            if (col - lo >= COL_LIMIT || kept >= STORE_DEPTH) begin
                full_hits++;
                return gpcsc_pkg::ST_FULL;
            end
            edge_col[kept] = col - lo;
            edge_row[kept] = row;
            edge_blk[kept] = b / rows_r;
            kept++;
            return gpcsc_pkg::ST_OK;
        endfunction

        function void build_tables();
            int unsigned ncols, mmax, p;
            int unsigned cursor[COL_LIMIT + 1];
            ncols = 0;
            mmax = 0;
            if (cols_c != 0) begin
                ncols = nodes / cols_c;
                if (ncols > COL_LIMIT) ncols = COL_LIMIT;
            end
            foreach (col_off[c]) col_off[c] = 0;
            for (int unsigned i = 0; i < kept; i++) begin
                if (edge_col[i] < ncols) begin
                    col_off[edge_col[i] + 1]++;
                    if (edge_blk[i] > mmax) mmax = edge_blk[i];
                end
            end
            for (int unsigned c = 1; c <= ncols; c++) col_off[c] += col_off[c - 1];
            for (int unsigned c = 0; c <= ncols; c++) cursor[c] = col_off[c];
            for (int unsigned m = 0; m <= mmax; m++) begin
                for (int unsigned i = 0; i < kept; i++) begin
                    if (edge_col[i] < ncols && edge_blk[i] == m) begin
                        p = cursor[edge_col[i]];
                        cursor[edge_col[i]]++;
                        if (p < STORE_DEPTH) row_idx[p] = edge_row[i];
                    end
                end
            end
            built_cols = ncols;
            built_total = col_off[ncols];
            built = 1;
            builds++;
        endfunction

        function void note_request(gpcsc_pkg::t_in_item it);
            gpcsc_pkg::t_out_item r;
            r = '0;
            case (it.op)
                gpcsc_pkg::OP_LOAD: r.status = load_edge(it.source_node, it.target_node);
                gpcsc_pkg::OP_BUILD: begin
                    build_tables();
                    r.value = built_total[15:0];
                end
                gpcsc_pkg::OP_RD_OFF: begin
                    if (built && it.position <= built_cols)
                        r.value = col_off[it.position][15:0];
                    else r.status = gpcsc_pkg::ST_RANGE;
                end
                default: begin
                    if (built && it.position < built_total)
                        r.value = row_idx[it.position][15:0];
                    else r.status = gpcsc_pkg::ST_RANGE;
                end
            endcase
            result_q = {result_q, r};
        endfunction

        function void check_result(gpcsc_pkg::t_out_item got);
            gpcsc_pkg::t_out_item want;
            checked++;
            if (result_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("ERROR: unexpected result %p", got);
                return;
            end
            want = result_q.pop_front();
            if (got.value !== want.value || got.status !== want.status) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %0d value %0d status %0d, expected %0d / %0d",
                             checked, got.value, got.status, want.value, want.status);
            end
        endfunction
    endclass

    logic       i_clk = 0;
    logic       i_rst_n = 0;
    logic       i_cfg_we = 0;
    logic [2:0] i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;
    logic       i_in_valid = 0;
    logic       o_in_ready;
    gpcsc_pkg::t_in_item  i_in_item = '0;
    logic       o_out_valid;
    logic       i_out_ready = 0;
    gpcsc_pkg::t_out_item o_out_item;

    csc_scoreboard sb = new;
    int in_idle_pct = 0, out_stall_pct = 0, hold_left = 0, requests = 0;
    longint cycles = 0;

    graph_2d_partition_csc_builder_unit uut (.*);

    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= out_stall_pct);
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_item);

    task automatic send(gpcsc_pkg::t_in_item it);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 0;
            @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_in_item <= it;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(it);
        requests++;
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (sb.result_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic configure(int unsigned n, int unsigned r, int unsigned c,
                             int unsigned mr, int unsigned mc);
        logic [15:0] vals[5];
        vals = '{n[15:0], r[15:0], c[15:0], mr[15:0], mc[15:0]};
        for (int k = 0; k < 5; k++) begin
            i_cfg_we <= 1;
            i_cfg_idx <= k[2:0];
            i_cfg_data <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 0;
        sb.nodes = n & 16'hFFFF;
        sb.rows_r = r & 5'h1F;
        sb.cols_c = c & 5'h1F;
        sb.mrow = mr & 4'hF;
        sb.mcol = mc & 4'hF;
        @(posedge i_clk);
    endtask

    function automatic gpcsc_pkg::t_in_item req(logic [1:0] op, int unsigned s,
                                                int unsigned d, int unsigned p);
        gpcsc_pkg::t_in_item it;
        it.op = op;
        it.source_node = s[15:0];
        it.target_node = d[15:0];
        it.position = p[12:0];
        return it;
    endfunction

    function automatic gpcsc_pkg::t_in_item owned_edge();
        int unsigned bsc, bsr, lc, b;
        bsc = sb.nodes / sb.cols_c;
        bsr = sb.nodes / (sb.rows_r * sb.cols_c);
        if (bsc == 0 || bsr == 0 || sb.mrow >= sb.rows_r || sb.mcol >= sb.cols_c)
            return req(gpcsc_pkg::OP_LOAD, $urandom_range(1, sb.nodes),
                       $urandom_range(1, sb.nodes), $urandom);
        lc = $urandom_range(0, (bsc > 1100 ? 1100 : bsc) - 1);
        b = sb.mrow + sb.rows_r * $urandom_range(0, sb.cols_c - 1);
        return req(gpcsc_pkg::OP_LOAD, sb.mcol * bsc + lc + 1,
                   b * bsr + $urandom_range(0, bsr - 1) + 1, $urandom);
    endfunction

    function automatic gpcsc_pkg::t_in_item random_request();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 55) return owned_edge();
        if (sel < 70) return req(gpcsc_pkg::OP_LOAD, $urandom, $urandom, $urandom);
        if (sel < 73) return req(gpcsc_pkg::OP_BUILD, $urandom, $urandom, $urandom);
        if (sel < 86)
            return req(gpcsc_pkg::OP_RD_OFF, $urandom, $urandom,
                       ($urandom_range(9) == 0) ? $urandom :
                       $urandom_range(0, sb.built_cols + 2));
        return req(gpcsc_pkg::OP_RD_ROW, $urandom, $urandom,
                   ($urandom_range(9) == 0) ? $urandom :
                   $urandom_range(0, sb.built_total + 2));
    endfunction

    task automatic random_phase(int count);
        for (int k = 0; k < count; k++) send(random_request());
        send(req(gpcsc_pkg::OP_BUILD, 0, 0, 0));
        for (int k = 0; k < 10; k++) send(random_request());
        drain();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: reset config, reads before build, bad nodes, edges of range
        configure(1024, 1, 1, 0, 0);
        send(req(gpcsc_pkg::OP_RD_OFF, 0, 0, 0));
        send(req(gpcsc_pkg::OP_RD_ROW, 0, 0, 0));
        send(req(gpcsc_pkg::OP_LOAD, 0, 5, 0));
        send(req(gpcsc_pkg::OP_LOAD, 5, 1025, 0));
        send(req(gpcsc_pkg::OP_LOAD, 65535, 65535, 8191));
        send(req(gpcsc_pkg::OP_LOAD, 1, 1, 0));
        send(req(gpcsc_pkg::OP_LOAD, 1024, 1024, 0));
        send(req(gpcsc_pkg::OP_LOAD, 1, 700, 0));
        send(req(gpcsc_pkg::OP_BUILD, 0, 0, 0));
        send(req(gpcsc_pkg::OP_RD_OFF, 0, 0, 1));
        send(req(gpcsc_pkg::OP_RD_OFF, 0, 0, 1024));
        send(req(gpcsc_pkg::OP_RD_OFF, 0, 0, 1025));
        send(req(gpcsc_pkg::OP_RD_ROW, 0, 0, 1));
        send(req(gpcsc_pkg::OP_RD_ROW, 0, 0, 3));
        send(req(gpcsc_pkg::OP_RD_ROW, 0, 0, 8191));
        drain();
        configure(65535, 1, 1, 0, 0);
        send(req(gpcsc_pkg::OP_LOAD, 65535, 1, 0));
        send(req(gpcsc_pkg::OP_LOAD, 1024, 65535, 0));
        send(req(gpcsc_pkg::OP_BUILD, 0, 0, 0));
        drain();
        configure(10, 4, 4, 0, 0);
        send(req(gpcsc_pkg::OP_LOAD, 1, 1, 0));
        drain();
        configure(64, 4, 4, 15, 0);
        send(req(gpcsc_pkg::OP_LOAD, 1, 1, 0));
        drain();
        configure(22, 2, 2, 0, 0);
        send(req(gpcsc_pkg::OP_LOAD, 1, 21, 0));
        send(req(gpcsc_pkg::OP_LOAD, 1, 22, 0));
        drain();

        in_idle_pct = 7;
        out_stall_pct = 66;
        configure(1024, 1, 1, 0, 0);
        random_phase(70);
        configure(65535, 16, 16, 15, 15);
        random_phase(70);
        configure(22, 2, 2, 1, 1);
        random_phase(60);

        in_idle_pct = 66;
        out_stall_pct = 7;
        configure(1, 1, 1, 0, 0);
        random_phase(50);
        configure(300, 3, 4, 2, 3);
        random_phase(70);
        configure(4000, 16, 1, 7, 0);
        random_phase(70);

        in_idle_pct = 0;
        out_stall_pct = 0;
        configure(65535, 1, 16, 0, 9);
        hold_left = 400;
        random_phase(70);
        configure(64, 4, 4, 3, 2);
        random_phase(70);

        // small grid, every edge loaded before the build owned
        configure(16, 1, 1, 0, 0);
        for (int k = 0; k < 10; k++) send(owned_edge());
        send(req(gpcsc_pkg::OP_BUILD, 0, 0, 0));
        for (int k = 0; k < 10; k++) send(random_request());
        drain();
        repeat (100) @(posedge i_clk);

        $display("Covered %0d requests, %0d builds, %0d edges kept, %0d store-full cases.",
                 requests, sb.builds, sb.kept, sb.full_hits);
        $display("Checked %0d results, %0d mismatches.", sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.result_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

[sim.f]
src/gpcsc_pkg.sv
src/gpcsc_div.sv
src/gpcsc_front.sv
src/gpcsc_fifo.sv
src/gpcsc_back.sv
src/graph_2d_partition_csc_builder_unit.sv
tb/tb.sv
